// File: sv/beat_pulse_customizer_defines.svh
// ----------------------------------------------------------------------------
// Beat pulse customizer assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// The enclosing module must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef BEAT_PULSE_CUSTOMIZER_DEFINES_SVH
`define BEAT_PULSE_CUSTOMIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define BPC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// when pre holds, post must hold at the next clock edge
`define BPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPC_ASSERT(lbl, expr, msg)
`define BPC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Beat pulse customizer package
// Shared widths, codes, config struct and indicator step function.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 14;
  localparam int INTERVAL_W     = 14;
  localparam int SKIP_W         = 5;
  localparam int INIT_W         = 7;
  localparam int TOTAL_W        = 7;
  localparam int POS_W          = 4;
  localparam int ACT_W          = 2;

  localparam logic [TOTAL_W-1:0] COUNT_SAT = 7'd65;
  localparam logic [POS_W-1:0]   IND_MAX   = 4'd8;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 14'd500;
  localparam logic [SKIP_W-1:0]     SKIP_RST     = 5'd1;
  localparam logic [INIT_W-1:0]     INIT_RST     = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_FIXED_RATE   = 3'd1,
    REG_SKIP_MODE    = 3'd2,
    REG_INVERT_MODE  = 3'd3,
    REG_INTERVAL     = 3'd4,
    REG_SKIP_AMOUNT  = 3'd5,
    REG_INITIAL_SKIP = 3'd6
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2
  } action_t;

  typedef struct packed {
    logic                  enable;
    logic                  fixed_rate_mode;
    logic                  skip_mode;
    logic                  invert_mode;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [SKIP_W-1:0]     skip_amount;
    logic [INIT_W-1:0]     initial_skip;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             down;
  } ind_t;

  // One step of a bouncing 0..IND_MAX indicator; direction flips at either end.
  function automatic ind_t step_ind(input ind_t cur);
    ind_t r;
    r = cur;
    if (cur.down) begin
      r.pos = (cur.pos == '0) ? '0 : cur.pos - 1'b1;
    end else begin
      r.pos = (cur.pos >= IND_MAX) ? IND_MAX : cur.pos + 1'b1;
    end
    if (r.pos == '0 || r.pos >= IND_MAX) begin
      r.down = ~cur.down;
    end
    return r;
  endfunction

endpackage

// File: sv/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Beat pulse customizer config registers
// Write-only register file; each write keeps the low bits of its register.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b1;
      cfg_r.fixed_rate_mode <= 1'b1;
      cfg_r.skip_mode       <= 1'b0;
      cfg_r.invert_mode     <= 1'b0;
      cfg_r.interval_ms     <= INTERVAL_RST;
      cfg_r.skip_amount     <= SKIP_RST;
      cfg_r.initial_skip    <= INIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       cfg_r.enable          <= cfg_wdata[0];
        REG_FIXED_RATE:   cfg_r.fixed_rate_mode <= cfg_wdata[0];
        REG_SKIP_MODE:    cfg_r.skip_mode       <= cfg_wdata[0];
        REG_INVERT_MODE:  cfg_r.invert_mode     <= cfg_wdata[0];
        REG_INTERVAL:     cfg_r.interval_ms     <= cfg_wdata[INTERVAL_W-1:0];
        REG_SKIP_AMOUNT:  cfg_r.skip_amount     <= cfg_wdata[SKIP_W-1:0];
        REG_INITIAL_SKIP: cfg_r.initial_skip    <= cfg_wdata[INIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/bpc_core.sv
// ----------------------------------------------------------------------------
// Beat pulse customizer decision core
// Tick state registers and the single-pass decision logic.
// ----------------------------------------------------------------------------
`include "beat_pulse_customizer_defines.svh"

module bpc_core
  import bpc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             advance,   // tick in the input stage is consumed
  input  logic             beat,
  input  logic             suppress,
  input  logic [NOW_W-1:0] now_ms,
  output action_t          action,
  output logic [POS_W-1:0] in_position,
  output logic [POS_W-1:0] out_position
);

  logic [TIME_WIDTH-1:0] last_emit_r, last_emit_nxt;
  logic [TOTAL_W-1:0]    beat_total_r, beat_total_nxt;
  logic [SKIP_W-1:0]     skip_cnt_r, skip_cnt_nxt;
  ind_t                  in_ind_r, in_ind_nxt;
  ind_t                  out_ind_r, out_ind_nxt;

  // timestamp cut (or zero-extended) to the time width
  logic [TIME_WIDTH+NOW_W-1:0] now_ext;
  logic [TIME_WIDTH-1:0]       now_t;
  logic [TIME_WIDTH-1:0]       elapsed;
  logic [TIME_WIDTH-1:0]       interval_ext;
  logic                        skip_phase;

  assign now_ext      = {{TIME_WIDTH{1'b0}}, now_ms};
  assign now_t        = now_ext[TIME_WIDTH-1:0];
  assign elapsed      = now_t - last_emit_r;
  assign interval_ext = {{(TIME_WIDTH-INTERVAL_W){1'b0}}, cfg.interval_ms};

  always_comb begin
    last_emit_nxt  = last_emit_r;
    beat_total_nxt = beat_total_r;
    skip_cnt_nxt   = skip_cnt_r;
    in_ind_nxt     = in_ind_r;
    out_ind_nxt    = out_ind_r;
    action         = ACT_NONE;
    skip_phase     = 1'b0;

    if (cfg.enable && !suppress) begin
      if (beat) begin
        in_ind_nxt = step_ind(in_ind_r);
        if (beat_total_r < COUNT_SAT) begin
          beat_total_nxt = beat_total_r + 1'b1;
        end
      end
      skip_phase = (cfg.initial_skip != '0) && (beat_total_nxt <= cfg.initial_skip);

      if (skip_phase) begin
        action = beat ? ACT_CLEAR : ACT_NONE;
      end else if (cfg.fixed_rate_mode) begin
        if (elapsed > interval_ext) begin
          last_emit_nxt = now_t;
          action        = ACT_SET;
        end else begin
          action = ACT_CLEAR;
        end
      end else if (cfg.skip_mode) begin
        action = ACT_CLEAR;
        if (beat) begin
          if (skip_cnt_r >= cfg.skip_amount) begin
            skip_cnt_nxt = '0;
            action       = ACT_SET;
          end else begin
            skip_cnt_nxt = skip_cnt_r + 1'b1;
          end
        end
      end else if (cfg.invert_mode) begin
        action = beat ? ACT_CLEAR : ACT_SET;
      end

      if (action == ACT_SET) begin
        out_ind_nxt = step_ind(out_ind_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_emit_r  <= '0;
      beat_total_r <= '0;
      skip_cnt_r   <= '0;
      in_ind_r     <= '0;
      out_ind_r    <= '0;
    end else if (advance) begin
      last_emit_r  <= last_emit_nxt;
      beat_total_r <= beat_total_nxt;
      skip_cnt_r   <= skip_cnt_nxt;
      in_ind_r     <= in_ind_nxt;
      out_ind_r    <= out_ind_nxt;
    end
  end

  assign in_position  = in_ind_nxt.pos;
  assign out_position = out_ind_nxt.pos;

  `BPC_ASSERT(a_in_pos_range, in_ind_r.pos <= IND_MAX, "input indicator out of range")
  `BPC_ASSERT(a_out_pos_range, out_ind_r.pos <= IND_MAX, "output indicator out of range")
  `BPC_ASSERT(a_total_sat, beat_total_r <= COUNT_SAT, "beat count past saturation")
  `BPC_ASSERT_NEXT(a_idle_hold, !advance, $stable(in_ind_r) && $stable(beat_total_r) && $stable(last_emit_r), "state moved without a tick")
  `BPC_ASSERT_NEXT(a_out_only_on_set, advance && action != ACT_SET, $stable(out_ind_r), "output indicator moved without set")

endmodule

// File: sv/beat_pulse_customizer.sv
// ----------------------------------------------------------------------------
// Beat pulse customizer
// Per-frame beat decision: none, clear beat or set beat, plus indicators.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per video frame tick with
//   in_beat_in, in_suppress and the free-running in_now_ms timestamp.
//   Result channel (out_valid/out_ready): one word per tick with
//   out_beat_action (0 none, 1 clear, 2 set), out_in_position and
//   out_out_position, both indicators as they stand after the tick.
//   Config port: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge; only write while no tick is in flight.
//   Path: an accepted tick enters the input register, then passes through
//   the decision logic into the result register, which drives out_valid.
//   Throughput: 1 tick per cycle unless out_ready stalls; the tick state
//   updates per tick, so consecutive ticks never wait on each other.
//   Stall: a stalled result holds in the result register while one more tick
//   waits in the input register; in_ready drops only when both are full.
//   Reset (rst_n low, synchronous): pipeline empty, indicators and counters
//   at zero, registers at their defaults (enabled, fixed rate, 500 ms).
// ----------------------------------------------------------------------------
module beat_pulse_customizer
  import bpc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input ticks
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_beat_in,
  input  logic                  in_suppress,
  input  logic [NOW_W-1:0]      in_now_ms,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACT_W-1:0]      out_beat_action,
  output logic [POS_W-1:0]      out_in_position,
  output logic [POS_W-1:0]      out_out_position
);

  cfg_t cfg;

  // input stage
  logic             in_vld_r;
  logic             beat_r;
  logic             sup_r;
  logic [NOW_W-1:0] now_r;

  // result stage
  logic             out_vld_r;
  logic [ACT_W-1:0] act_r;
  logic [POS_W-1:0] in_pos_r;
  logic [POS_W-1:0] out_pos_r;

  action_t          action;
  logic [POS_W-1:0] in_pos_nxt;
  logic [POS_W-1:0] out_pos_nxt;

  logic advance;   // input stage moves into the result stage
  logic in_fire;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_fire  = in_valid && in_ready;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .advance      (advance),
    .beat         (beat_r),
    .suppress     (sup_r),
    .now_ms       (now_r),
    .action       (action),
    .in_position  (in_pos_nxt),
    .out_position (out_pos_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_r <= in_beat_in;
      sup_r  <= in_suppress;
      now_r  <= in_now_ms;
    end
    if (advance) begin
      act_r     <= action;
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_beat_action  = act_r;
  assign out_in_position  = in_pos_r;
  assign out_out_position = out_pos_r;

endmodule
